// ===== hdl/crr_pkg.sv =====
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types and constants of the chained range remap block.
// ----------------------------------------------------------------------------
package crr_pkg;

    localparam int STAGES  = 8;
    localparam int ENTRIES = 64;
    localparam int STAGE_W = $clog2(STAGES);
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int IDX_W   = STAGE_W + SLOT_W;
    localparam int DEPTH   = STAGES * ENTRIES;
    localparam int VAL_W   = 64;
    localparam int CNT_W   = 4;
    localparam int MASK_W  = 8;

    // input field widths fixed by the item format
    localparam int CMD_W      = 1;
    localparam int IN_STAGE_W = 3;
    localparam int IN_SLOT_W  = 6;

    // command codes of an input beat
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_MAP  = 1'b1;

    // operation kinds after classification
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_EMPTY,
        OP_MAP,
        OP_DROP
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   dest;
        logic [VAL_W-1:0]   src;
        logic [VAL_W-1:0]   len;
        logic [VAL_W-1:0]   value;
    } op_t;

    // one table entry as stored in the ram
    typedef struct packed {
        logic               valid;
        logic [VAL_W-1:0]   dest;
        logic [VAL_W-1:0]   src;
        logic [VAL_W-1:0]   len;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/crr_ifs.sv =====
// ----------------------------------------------------------------------------
// crr_ifs
// Valid/ready channel interfaces for input and result beats.
// ----------------------------------------------------------------------------
interface crr_in_if;
    logic                               valid;
    logic                               ready;
    logic [crr_pkg::CMD_W-1:0]          command;
    logic [crr_pkg::IN_STAGE_W-1:0]     stage;
    logic [crr_pkg::IN_SLOT_W-1:0]      slot;
    logic [crr_pkg::VAL_W-1:0]          dest_start;
    logic [crr_pkg::VAL_W-1:0]          source_start;
    logic [crr_pkg::VAL_W-1:0]          range_length;
    logic [crr_pkg::VAL_W-1:0]          query_value;

    modport source (output valid, command, stage, slot, dest_start, source_start,
                    range_length, query_value, input ready);
    modport sink (input valid, command, stage, slot, dest_start, source_start,
                  range_length, query_value, output ready);
endinterface

interface crr_out_if;
    logic                           valid;
    logic                           ready;
    logic [crr_pkg::VAL_W-1:0]      mapped_value;
    logic [crr_pkg::MASK_W-1:0]     hit_mask;

    modport source (output valid, mapped_value, hit_mask, input ready);
    modport sink (input valid, mapped_value, hit_mask, output ready);
endinterface

// ===== hdl/crr_ram.sv =====
// ----------------------------------------------------------------------------
// crr_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module crr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [WIDTH-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic [WIDTH-1:0]            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/crr_front.sv =====
// ----------------------------------------------------------------------------
// crr_front
// Accepts input beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module crr_front (
    input  logic            clk,
    input  logic            rst_n,
    crr_in_if.sink          in_ch,
    input  logic            clear_busy,
    output logic            q_valid,
    input  logic            q_ready,
    output crr_pkg::op_t    q_op
);

    crr_pkg::op_t   slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    crr_pkg::op_t   op_in;
    logic           push;
    logic           pop;

    // classify the incoming beat
    always_comb
    begin
        op_in.idx   = {in_ch.stage[crr_pkg::STAGE_W-1:0], in_ch.slot[crr_pkg::SLOT_W-1:0]};
        op_in.dest  = in_ch.dest_start;
        op_in.src   = in_ch.source_start;
        op_in.len   = in_ch.range_length;
        op_in.value = in_ch.query_value;
        if (in_ch.command == crr_pkg::CMD_MAP)
        begin
            op_in.kind = crr_pkg::OP_MAP;
        end
        else if ((32'(in_ch.stage) >= crr_pkg::STAGES) || (32'(in_ch.slot) >= crr_pkg::ENTRIES))
        begin
            op_in.kind = crr_pkg::OP_DROP;
        end
        else if (in_ch.range_length == '0)
        begin
            op_in.kind = crr_pkg::OP_EMPTY;
        end
        else
        begin
            op_in.kind = crr_pkg::OP_WRITE;
        end
    end

    assign in_ch.ready = (count_reg != 2'd2) && !clear_busy;
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != 2'd0);
    assign pop         = q_valid && q_ready;
    assign q_op        = slot_reg[rd_ptr_reg];

    // two-entry queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= op_in;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hdl/crr_back.sv =====
// ----------------------------------------------------------------------------
// crr_back
// Executes queued operations: table writes and stage-by-stage range scans.
// ----------------------------------------------------------------------------
module crr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [crr_pkg::CNT_W-1:0]       cfg_data,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  crr_pkg::op_t                    q_op,
    output logic                            clear_busy,
    crr_out_if.source                       out_ch
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [crr_pkg::IDX_W-1:0]      clr_reg, clr_next;
    logic [crr_pkg::STAGE_W:0]      stage_reg, stage_next;
    logic [crr_pkg::SLOT_W:0]       slot_reg, slot_next;
    logic                           pend_reg, pend_next;
    logic [crr_pkg::VAL_W-1:0]      value_reg, value_next;
    logic [crr_pkg::MASK_W-1:0]     mask_reg, mask_next;
    logic [crr_pkg::CNT_W-1:0]      num_reg, num_next;
    logic [crr_pkg::CNT_W-1:0]      count_reg;
    logic                           oval_reg, oval_next;
    logic [crr_pkg::VAL_W-1:0]      oval_value_reg, oval_value_next;
    logic [crr_pkg::MASK_W-1:0]     omask_reg, omask_next;

    logic                           we;
    logic [crr_pkg::IDX_W-1:0]      waddr;
    crr_pkg::entry_t                wdata;
    logic [crr_pkg::IDX_W-1:0]      raddr;
    logic [crr_pkg::ENTRY_W-1:0]    rdata_raw;
    crr_pkg::entry_t                rdata;
    logic [crr_pkg::VAL_W-1:0]      diff;
    logic                           holds;
    logic                           issuing;
    logic [crr_pkg::STAGE_W:0]      stage_inc;

    crr_ram #(
        .WIDTH (crr_pkg::ENTRY_W),
        .DEPTH (crr_pkg::DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata      = rdata_raw;
    assign clear_busy = (state_reg == ST_CLEAR);

    // range match on the entry read last cycle
    assign diff      = value_reg - rdata.src;
    assign holds     = rdata.valid && (value_reg >= rdata.src) && (diff <= (rdata.len - 1'b1));
    assign issuing   = (slot_reg != (crr_pkg::SLOT_W+1)'(crr_pkg::ENTRIES));
    assign stage_inc = stage_reg + 1'b1;
    assign raddr     = {stage_reg[crr_pkg::STAGE_W-1:0], slot_reg[crr_pkg::SLOT_W-1:0]};

    assign out_ch.valid        = oval_reg;
    assign out_ch.mapped_value = oval_value_reg;
    assign out_ch.hit_mask     = omask_reg;

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        stage_next      = stage_reg;
        slot_next       = slot_reg;
        pend_next       = 1'b0;
        value_next      = value_reg;
        mask_next       = mask_reg;
        num_next        = num_reg;
        oval_next       = oval_reg && !out_ch.ready;
        oval_value_next = oval_value_reg;
        omask_next      = omask_reg;
        q_ready         = 1'b0;
        we              = 1'b0;
        waddr           = q_op.idx;
        wdata           = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == crr_pkg::IDX_W'(crr_pkg::DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    case (q_op.kind)
                        crr_pkg::OP_WRITE:
                        begin
                            we    = 1'b1;
                            wdata = '{valid: 1'b1, dest: q_op.dest, src: q_op.src,
                                      len: q_op.len};
                        end
                        crr_pkg::OP_EMPTY:
                        begin
                            we = 1'b1;
                        end
                        crr_pkg::OP_MAP:
                        begin
                            value_next = q_op.value;
                            mask_next  = '0;
                            stage_next = '0;
                            slot_next  = '0;
                            if (32'(count_reg) > crr_pkg::STAGES)
                            begin
                                num_next = crr_pkg::CNT_W'(crr_pkg::STAGES);
                            end
                            else
                            begin
                                num_next = count_reg;
                            end
                            state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                pend_next = issuing;
                slot_next = slot_reg + (crr_pkg::SLOT_W+1)'(issuing);
                if ((pend_reg && holds) || (!pend_reg && !issuing))
                begin
                    if (pend_reg && holds)
                    begin
                        value_next = rdata.dest + diff;
                        mask_next  = mask_reg | (crr_pkg::MASK_W'(1) << stage_reg);
                    end
                    stage_next = stage_inc;
                    slot_next  = '0;
                    pend_next  = 1'b0;
                    if (crr_pkg::CNT_W'(stage_inc) == num_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!oval_reg || out_ch.ready)
                begin
                    oval_next       = 1'b1;
                    oval_value_next = value_reg;
                    omask_next      = mask_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            stage_reg      <= '0;
            slot_reg       <= '0;
            pend_reg       <= 1'b0;
            num_reg        <= '0;
            count_reg      <= crr_pkg::CNT_W'(7);
            oval_reg       <= 1'b0;
            value_reg      <= '0;
            mask_reg       <= '0;
            oval_value_reg <= '0;
            omask_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            stage_reg      <= stage_next;
            slot_reg       <= slot_next;
            pend_reg       <= pend_next;
            num_reg        <= num_next;
            oval_reg       <= oval_next;
            value_reg      <= value_next;
            mask_reg       <= mask_next;
            oval_value_reg <= oval_value_next;
            omask_reg      <= omask_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== hdl/chained_range_remap.sv =====
// ----------------------------------------------------------------------------
// chained_range_remap
// Chain of range mapping tables: loads write entries, maps translate values.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     command stage slot dest_start source_start
//                                 range_length query_value
//  out_ch    out  valid/ready     mapped_value hit_mask
//  cfg       in   cfg_we          cfg_data (stage_count)
//
//  a load is a single table write in the back end; a map scans up to
//  min(stage_count, STAGES) stages and leaves a stage early when a slot hits,
//  reading one entry per cycle through the read port of the table ram.
//  after reset a clearing pass over all 512 entries empties the table; no input
//  beat is accepted until it ends.
//  a two-deep queue and the result register let each side stall alone.
// ----------------------------------------------------------------------------
module chained_range_remap (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [crr_pkg::CNT_W-1:0]   cfg_data,
    crr_in_if.sink                      in_ch,
    crr_out_if.source                   out_ch
);

    logic           q_valid;
    logic           q_ready;
    crr_pkg::op_t   q_op;
    logic           clear_busy;

    // accept and classify
    crr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .clear_busy (clear_busy),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_op       (q_op)
    );

    // execute
    crr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_op       (q_op),
        .clear_busy (clear_busy),
        .out_ch     (out_ch)
    );

endmodule

// ===== tb/tb_chained_range_remap.sv =====
// ----------------------------------------------------------------------------
// tb_chained_range_remap
// Self-checking bench for the chained range remap block: directed table of
// loads and maps, some with typed-in answers, then random table contents and
// queries checked against an in-bench translation model, under three idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chained_range_remap;

    localparam int MAP_CYCLES = crr_pkg::STAGES * (crr_pkg::ENTRIES + 2) + 16;
    localparam int WATCHDOG   = 20 * MAP_CYCLES + 2000;

    typedef struct {
        logic [crr_pkg::CMD_W-1:0]      command;
        logic [crr_pkg::IN_STAGE_W-1:0] stage;
        logic [crr_pkg::IN_SLOT_W-1:0]  slot;
        logic [crr_pkg::VAL_W-1:0]      dest_start;
        logic [crr_pkg::VAL_W-1:0]      source_start;
        logic [crr_pkg::VAL_W-1:0]      range_length;
        logic [crr_pkg::VAL_W-1:0]      query_value;
    } beat_t;

    typedef struct {
        logic [crr_pkg::VAL_W-1:0]  mapped_value;
        logic [crr_pkg::MASK_W-1:0] hit_mask;
    } remap_t;

    typedef struct {
        beat_t  b;
        bit     known;
        remap_t r;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [crr_pkg::CNT_W-1:0] cfg_data;

    crr_in_if  in_ch();
    crr_out_if out_ch();

    chained_range_remap dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // model state
    logic [crr_pkg::VAL_W-1:0] tbl_dest [crr_pkg::DEPTH];
    logic [crr_pkg::VAL_W-1:0] tbl_src  [crr_pkg::DEPTH];
    logic [crr_pkg::VAL_W-1:0] tbl_len  [crr_pkg::DEPTH];
    bit                        tbl_used [crr_pkg::DEPTH];
    logic [crr_pkg::CNT_W-1:0] stage_cnt;

    remap_t pending_remaps[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatches = 0;
    int     row_errors = 0;
    int     maps_seen = 0;
    int     loads_sent;
    int     idle_cycles = 0;
    row_t   rows[$];

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // apply one beat to the model, push an expectation for a map
    function automatic void model_apply(beat_t b);
        int unsigned idx;
        int n;
        logic [crr_pkg::VAL_W-1:0] v;
        logic [crr_pkg::MASK_W-1:0] m;
        bit hit;
        idx = 32'({b.stage, b.slot});
        if (b.command == crr_pkg::CMD_LOAD)
        begin
            if (b.range_length == 0)
            begin
                tbl_used[idx] = 0;
            end
            else
            begin
                tbl_dest[idx] = b.dest_start;
                tbl_src[idx]  = b.source_start;
                tbl_len[idx]  = b.range_length;
                tbl_used[idx] = 1;
            end
            return;
        end
        v = b.query_value;
        m = '0;
        n = (int'(stage_cnt) > crr_pkg::STAGES) ? crr_pkg::STAGES : int'(stage_cnt);
        for (int s = 0; s < n; s++)
        begin
            hit = 0;
            for (int k = 0; k < crr_pkg::ENTRIES && !hit; k++)
            begin
                idx = s * crr_pkg::ENTRIES + k;
                if (tbl_used[idx] && v >= tbl_src[idx]
                    && (v - tbl_src[idx]) <= (tbl_len[idx] - 64'd1))
                begin
                    hit = 1;
                    v = tbl_dest[idx] + (v - tbl_src[idx]);
                end
            end
            if (hit)
            begin
                m[s] = 1'b1;
            end
        end
        pending_remaps.push_back('{v, m});
    endfunction

    // result side: stall and compare
    always @(posedge clk or negedge rst_n)
    begin
        remap_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                maps_seen++;
                if (pending_remaps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h/%h",
                                 out_ch.mapped_value, out_ch.hit_mask);
                end
                else
                begin
                    e = pending_remaps.pop_front();
                    if (e.mapped_value !== out_ch.mapped_value
                        || e.hit_mask !== out_ch.hit_mask)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h/%h got %h/%h",
                                     e.mapped_value, e.hit_mask,
                                     out_ch.mapped_value, out_ch.hit_mask);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("watchdog expired");
            $display("chained_range_remap test failed");
            $finish;
        end
    end

    // send one beat, with random idle ahead of it; valid stays up afterwards
    task automatic send_beat(beat_t b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= b.command;
        in_ch.stage        <= b.stage;
        in_ch.slot         <= b.slot;
        in_ch.dest_start   <= b.dest_start;
        in_ch.source_start <= b.source_start;
        in_ch.range_length <= b.range_length;
        in_ch.query_value  <= b.query_value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        model_apply(b);
        if (b.command == crr_pkg::CMD_LOAD) loads_sent++;
    endtask

    // wait for all results, then let the back end settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_remaps.size() != 0) @(posedge clk);
        repeat (MAP_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [crr_pkg::CNT_W-1:0] c);
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we   <= 1'b0;
        stage_cnt = c;
    endtask

    function automatic logic [crr_pkg::VAL_W-1:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic beat_t load_beat(int st, int sl, logic [crr_pkg::VAL_W-1:0] d,
                                        logic [crr_pkg::VAL_W-1:0] s,
                                        logic [crr_pkg::VAL_W-1:0] l);
        beat_t b;
        b = '{crr_pkg::CMD_LOAD, crr_pkg::IN_STAGE_W'(st), crr_pkg::IN_SLOT_W'(sl),
              d, s, l, rnd64()};
        return b;
    endfunction

    function automatic beat_t map_beat(logic [crr_pkg::VAL_W-1:0] q);
        beat_t b;
        b = '{crr_pkg::CMD_MAP, crr_pkg::IN_STAGE_W'($urandom()),
              crr_pkg::IN_SLOT_W'($urandom()), rnd64(), rnd64(), rnd64(), q};
        return b;
    endfunction

    // random content: loads mostly cluster around a small value space
    function automatic beat_t rand_beat(int span_sel);
        logic [crr_pkg::VAL_W-1:0] base;
        base = span_sel ? {crr_pkg::VAL_W{1'b1}} - 64'd4000 : 64'd0;
        if ($urandom_range(99) < 40)
        begin
            case ($urandom_range(9))
                0: return load_beat($urandom_range(7), $urandom_range(63),
                                    rnd64(), rnd64(), rnd64());
                1: return load_beat($urandom_range(7), $urandom_range(63),
                                    rnd64(), rnd64(), 64'd0);
                default: return load_beat($urandom_range(7), $urandom_range(15),
                                    base + 64'($urandom_range(4000)),
                                    base + 64'($urandom_range(4000)),
                                    ($urandom_range(3) == 0) ? rnd64()
                                        : 64'($urandom_range(1, 1500)));
            endcase
        end
        if ($urandom_range(9) == 0) return map_beat(rnd64());
        return map_beat(base + 64'($urandom_range(4000)));
    endfunction

    initial
    begin
        remap_t got_r;
        loads_sent = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.command = crr_pkg::CMD_LOAD; in_ch.stage = '0;
        in_ch.slot = '0; in_ch.dest_start = '0; in_ch.source_start = '0;
        in_ch.range_length = '0; in_ch.query_value = '0;
        stage_cnt = 4'd7;
        for (int i = 0; i < crr_pkg::DEPTH; i++) tbl_used[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; expectation typed in where obvious
        rows.push_back('{map_beat(64'd0), 1, '{64'd0, 8'h00}});
        rows.push_back('{map_beat({crr_pkg::VAL_W{1'b1}}), 1,
                         '{{crr_pkg::VAL_W{1'b1}}, 8'h00}});
        rows.push_back('{load_beat(0, 0, 64'd100, 64'd10, 64'd5), 0, '{0, 0}});
        rows.push_back('{map_beat(64'd12), 1, '{64'd102, 8'h01}});
        rows.push_back('{map_beat(64'd15), 1, '{64'd15, 8'h00}});
        rows.push_back('{map_beat(64'd14), 1, '{64'd104, 8'h01}});
        rows.push_back('{load_beat(0, 1, 64'd0, 64'd10, 64'd5), 0, '{0, 0}});
        rows.push_back('{map_beat(64'd10), 1, '{64'd100, 8'h01}});
        // top range clipped, not wrapped
        rows.push_back('{load_beat(7, 63, 64'd0, {crr_pkg::VAL_W{1'b1}},
                                   {crr_pkg::VAL_W{1'b1}}), 0, '{0, 0}});
        rows.push_back('{load_beat(1, 63, 64'd5, {crr_pkg::VAL_W{1'b1}} - 64'd1, 64'd9),
                         0, '{0, 0}});
        rows.push_back('{map_beat({crr_pkg::VAL_W{1'b1}}), 0, '{0, 0}});
        rows.push_back('{map_beat(64'd0), 1, '{64'd0, 8'h00}});
        // dest wrap
        rows.push_back('{load_beat(2, 0, {crr_pkg::VAL_W{1'b1}}, 64'd200, 64'd10),
                         0, '{0, 0}});
        rows.push_back('{map_beat(64'd203), 0, '{0, 0}});
        // emptied slot
        rows.push_back('{load_beat(0, 0, 64'd0, 64'd0, 64'd0), 0, '{0, 0}});
        rows.push_back('{map_beat(64'd12), 0, '{0, 0}});
        rows.push_back('{load_beat(3, 32, {crr_pkg::VAL_W{1'b1}}, 64'd0,
                         {crr_pkg::VAL_W{1'b1}}), 0, '{0, 0}});
        rows.push_back('{map_beat(64'h5555_aaaa_5555_aaaa), 0, '{0, 0}});
        foreach (rows[i])
        begin
            send_beat(rows[i].b);
            if (rows[i].known)
            begin
                got_r = pending_remaps[$];
                if (got_r.mapped_value !== rows[i].r.mapped_value
                    || got_r.hit_mask !== rows[i].r.hit_mask)
                begin
                    row_errors++;
                    if (row_errors <= 10)
                        $display("row %0d: table %h/%h, model %h/%h", i,
                                 rows[i].r.mapped_value, rows[i].r.hit_mask,
                                 got_r.mapped_value, got_r.hit_mask);
                end
            end
        end
        drain();

        // stage counts: zero, beyond max, max, then random phases
        write_count(4'd0);
        send_beat(map_beat(64'd12));
        send_beat(map_beat(64'd203));
        drain();
        write_count(4'd15);
        send_beat(map_beat(64'd203));
        drain();
        write_count(4'd8);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 57 : 0;
            recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 19 : 0;
            for (int i = 0; i < 384; i++)
            begin
                send_beat(rand_beat(i % 97 > 80));
                if (i == 200)
                begin
                    // sender holds until every result is back
                    in_ch.valid <= 1'b0;
                    while (pending_remaps.size() != 0) @(posedge clk);
                end
            end
            drain();
            write_count((ph == 0) ? 4'd1 : (ph == 1) ? 4'd8 : 4'd3);
        end
        send_beat(map_beat(64'd100));
        drain();

        $display("covered %0d loads and %0d checked maps over stage counts 0..15",
                 loads_sent, maps_seen);
        if (mismatches == 0 && row_errors == 0 && pending_remaps.size() == 0)
            $display("chained_range_remap test passed");
        else
            $display("chained_range_remap test failed");
        $finish;
    end

endmodule
